@@ rtl/core/label_bounding_box_3d_assert.svh @@
// assertion macros shared by the bounding box checker
// no dependencies; included by the files that assert
`ifndef LABEL_BOUNDING_BOX_3D_ASSERT_SVH
`define LABEL_BOUNDING_BOX_3D_ASSERT_SVH

// same-cycle implication
`define LBB3_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbb3 check failed");

// next-cycle implication
`define LBB3_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbb3 check failed");

`endif

@@ rtl/core/lbb3_pkg.sv @@
// types and constants of the 3d label bounding box block
// no dependencies; imported by every module of the block
`default_nettype none

package lbb3_pkg;

   localparam int MAX_EXTENT = 4096;
   localparam int AXES       = 3;
   localparam int COORD_W    = 12;
   localparam int EXT_W      = 13;
   localparam int LABEL_W    = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = EXT_W;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 80;

   localparam logic [LABEL_W-1:0] LABEL_MATCH  = LABEL_W'(1);
   localparam logic [EXT_W-1:0]   EXTENT_RESET = EXT_W'(MAX_EXTENT);

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [EXT_W-1:0]   ext_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MARGIN   = 3'd0,
      CSR_ORIGIN_X = 3'd1,
      CSR_ORIGIN_Y = 3'd2,
      CSR_ORIGIN_Z = 3'd3,
      CSR_EXTENT_X = 3'd4,
      CSR_EXTENT_Y = 3'd5,
      CSR_EXTENT_Z = 3'd6
   } csr_index_type;

   typedef struct packed {
      coord_type                margin;
      coord_type [AXES-1:0]     origin;
      ext_type   [AXES-1:0]     extent;
   } csr_type;

   typedef struct packed {
      logic [LABEL_W-1:0]       label;
      coord_type [AXES-1:0]     pos;
      logic                     last;
   } voxel_type;

   typedef struct packed {
      logic                     found;
      coord_type [AXES-1:0]     lo;
      coord_type [AXES-1:0]     hi;
   } extremes_type;

endpackage

`default_nettype wire

@@ rtl/core/label_bounding_box_3d.sv @@
// path: a taken voxel is held in the input register, then its box in the result register
// throughput: one voxel per cycle, set by the single accumulate stage
// a last voxel waits only while a previous result is still not taken
// reset: synchronous, clears accumulators, valid flags and configuration
// (extent registers reset to the maximum extent, the rest to zero)
`default_nettype none

module label_bounding_box_3d (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // label, pos_x, pos_y, pos_z, zero fill
   input  wire logic [lbb3_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z, zero fill
   output logic [lbb3_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // found_any
   output logic                                rsp_tuser,
   input  wire logic                           csr_wen,
   input  wire logic [lbb3_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [lbb3_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lbb3_pkg::*;

   csr_type      cfg;
   voxel_type    req_voxel;
   extremes_type ext_next;
   logic         stage_free;
   logic         done;
   logic         out_busy;
   logic         req_take;

   assign req_voxel.label  = req_tdata[15:0];
   assign req_voxel.pos[0] = req_tdata[27:16];
   assign req_voxel.pos[1] = req_tdata[39:28];
   assign req_voxel.pos[2] = req_tdata[51:40];
   assign req_voxel.last   = req_tlast;

   assign req_tready = stage_free;
   assign req_take   = req_tvalid && stage_free;

   lbb3_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbb3_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .req_take   (req_take),
      .req_voxel  (req_voxel),
      .out_busy   (out_busy),
      .stage_free (stage_free),
      .done       (done),
      .ext_next   (ext_next)
   );

   lbb3_bound u_bound (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .done       (done),
      .ext_next   (ext_next),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .out_busy   (out_busy)
   );

endmodule

`default_nettype wire

@@ rtl/core/lbb3_csr.sv @@
// configuration registers: margin, region origin and region extent
// depends on lbb3_pkg
`default_nettype none

module lbb3_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wen,
   input  wire logic [lbb3_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [lbb3_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lbb3_pkg::csr_type                   cfg
);
   import lbb3_pkg::*;

   csr_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_MARGIN:   cfg_in.margin    = csr_wdata[COORD_W-1:0];
            CSR_ORIGIN_X: cfg_in.origin[0] = csr_wdata[COORD_W-1:0];
            CSR_ORIGIN_Y: cfg_in.origin[1] = csr_wdata[COORD_W-1:0];
            CSR_ORIGIN_Z: cfg_in.origin[2] = csr_wdata[COORD_W-1:0];
            CSR_EXTENT_X: cfg_in.extent[0] = csr_wdata;
            CSR_EXTENT_Y: cfg_in.extent[1] = csr_wdata;
            CSR_EXTENT_Z: cfg_in.extent[2] = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.margin <= '0;
         cfg_ff.origin <= '0;
         cfg_ff.extent <= {AXES{EXTENT_RESET}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/lbb3_acc.sv @@
// input register and per-axis min/max accumulators
// depends on lbb3_pkg
`default_nettype none

module lbb3_acc (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_take,
   input  wire lbb3_pkg::voxel_type    req_voxel,
   input  wire logic                   out_busy,
   output logic                        stage_free,
   output logic                        done,
   output lbb3_pkg::extremes_type      ext_next
);
   import lbb3_pkg::*;

   voxel_type    voxel_ff;
   logic         valid_ff, valid_in;
   extremes_type acc_ff, acc_in;
   logic         advance;
   logic         hit;

   // a last voxel waits while the result register is full and not being taken
   assign advance    = valid_ff && !(voxel_ff.last && out_busy);
   assign stage_free = !valid_ff || advance;
   assign done       = advance && voxel_ff.last;
   assign hit        = (voxel_ff.label == LABEL_MATCH);

   always_comb begin
      ext_next = acc_ff;
      if (hit) begin
         ext_next.found = 1'b1;
         for (int a = 0; a < AXES; a++) begin
            if (!acc_ff.found) begin
               ext_next.lo[a] = voxel_ff.pos[a];
               ext_next.hi[a] = voxel_ff.pos[a];
            end else begin
               if (voxel_ff.pos[a] < acc_ff.lo[a]) ext_next.lo[a] = voxel_ff.pos[a];
               if (voxel_ff.pos[a] > acc_ff.hi[a]) ext_next.hi[a] = voxel_ff.pos[a];
            end
         end
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (advance) begin
         acc_in = voxel_ff.last ? '0 : ext_next;
      end
      valid_in = req_take ? 1'b1 : (advance ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         voxel_ff <= req_voxel;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lbb3_bound.sv @@
// margin widening, origin/extent clamping and the result register
// depends on lbb3_pkg
`default_nettype none

module lbb3_bound (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lbb3_pkg::csr_type              cfg,
   input  wire logic                           done,
   input  wire lbb3_pkg::extremes_type         ext_next,
   input  wire logic                           rsp_tready,
   output logic                                rsp_tvalid,
   output logic [lbb3_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                out_busy
);
   import lbb3_pkg::*;

   coord_type [AXES-1:0] box_lo;
   ext_type   [AXES-1:0] box_hi;
   logic [EXT_W-1:0]     diff  [AXES];
   logic [EXT_W-1:0]     total [AXES];

   logic                        valid_ff, valid_in;
   logic [RSP_DATA_W-1:0]       data_ff;
   logic                        found_ff;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         // top bit of diff is the borrow: widened bound fell below zero
         diff[a]  = {1'b0, ext_next.lo[a]} - {1'b0, cfg.margin};
         total[a] = {1'b0, ext_next.hi[a]} + {1'b0, cfg.margin};
         if (diff[a][EXT_W-1] || (diff[a][COORD_W-1:0] < cfg.origin[a])) begin
            box_lo[a] = cfg.origin[a];
         end else begin
            box_lo[a] = diff[a][COORD_W-1:0];
         end
         box_hi[a] = (total[a] > cfg.extent[a]) ? cfg.extent[a] : total[a];
      end
   end

   assign out_busy = valid_ff && !rsp_tready;
   assign valid_in = done ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         data_ff  <= {5'b0, box_hi[2], box_hi[1], box_hi[0],
                      box_lo[2], box_lo[1], box_lo[0]};
         found_ff <= ext_next.found;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = found_ff;

endmodule

`default_nettype wire

@@ rtl/core/lbb3_checker.sv @@
// port-level checks for the bounding box block, bound to the top level
// depends on lbb3_pkg and label_bounding_box_3d_assert.svh
`default_nettype none

`include "label_bounding_box_3d_assert.svh"

module lbb3_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic                           req_tlast,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [lbb3_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           rsp_tuser
);
   import lbb3_pkg::*;

   logic req_fire;
   logic req_fire_last;

   assign req_fire      = req_tvalid && req_tready;
   assign req_fire_last = req_fire && req_tlast;

   // a stalled result holds
   `LBB3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a fresh result must trace back to a last voxel that was taken
   `LBB3_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_tvalid),
      $past(req_fire_last, 2))

   // request side only backs off behind a stalled result
   `LBB3_ASSERT_NOW(a_req_stall, clock, reset, !req_tready,
      rsp_tvalid && !rsp_tready)

   // nothing left pending out of reset
   `LBB3_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind label_bounding_box_3d lbb3_checker u_lbb3_checker (.*);

`default_nettype wire
